// ----- rtl/pbd_pkg.sv -----
// Shared types and constants for the PPG beat detector and rate averager.
package pbd_pkg;

  localparam int SAMPLE_W    = 18;
  localparam int TIME_W      = 32;
  localparam int RATE_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int LEVEL_W     = 18;
  localparam int SUM9_W      = 22;
  localparam int RECIP_W     = 23;
  localparam int PROD_W      = SUM9_W + RECIP_W;
  localparam int LEVEL_SHIFT = 26;

  // Weight of the old level in the running filter.
  localparam logic [3:0] LEVEL_GAIN = 4'd9;

  // ceil(2^26 / 10): exact truncating division by ten for any 22-bit value.
  localparam logic [RECIP_W-1:0] LEVEL_RECIP = 23'd6710887;

  // Milliseconds per minute.
  localparam logic [RATE_W-1:0] BPM_NUMERATOR = 16'd60000;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL     = 2'd2;

  localparam logic [CFG_W-1:0] RST_THRESHOLD_OFFSET = 16'd2000;
  localparam logic [CFG_W-1:0] RST_MIN_INTERVAL     = 16'd300;
  localparam logic [CFG_W-1:0] RST_MAX_INTERVAL     = 16'd2000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_LEVEL,
    ST_CMP,
    ST_DIV_BPM,
    ST_SUM,
    ST_DIV_AVG,
    ST_OUT
  } state_t;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/pbd_ram.sv -----
// Synchronous single-port-write, single-port-read memory for the rate window.
module pbd_ram #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pbd_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module pbd_div
  import pbd_pkg::*;
#(
  parameter int DIVIDEND_W = 20,
  parameter int DIVISOR_W  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  div_req_t              req,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output div_stat_t             stat,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] den;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0] rem_sh;
  logic [DIVISOR_W:0] diff;
  logic               take;

  assign rem_sh = {rem, quo[DIVIDEND_W-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign take   = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        den  <= divisor;
      end else if (busy) begin
        rem <= take ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], take};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ----- rtl/ppg_beat_detect_bpm_average_core.sv -----
// Top level: PPG beat detector with a windowed mean of beat rates.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   in      | in_valid/in_ready, ir_sample,     | sink
//           | time_ms                           |
//   out     | out_valid/out_ready, beat,        | source
//           | bpm_raw, bpm_avg                  |
//   cfg     | cfg_valid/cfg_ready, cfg_index,   | sink
//           | cfg_data                          |
//
// A sample without a beat passes through ST_SCALE, ST_LEVEL and ST_CMP to ST_OUT, which loads
// the output register. A beat adds the bpm divide, the window sum through the memory read
// port and the mean divide before ST_OUT.
// One sample is worked on at a time.
// Reset is synchronous; the window memory is not cleared, a fill count limits
// the sum to entries already written. A stalled output holds the next result
// in the sequencer while the output register still waits for its transfer.
module ppg_beat_detect_bpm_average_core
  import pbd_pkg::*;
#(
  parameter int WINDOW_LEN = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SAMPLE_W-1:0]  ir_sample,
  input  logic [TIME_W-1:0]    time_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 beat,
  output logic [RATE_W-1:0]    bpm_raw,
  output logic [RATE_W-1:0]    bpm_avg,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W = RATE_W + CNT_W;

  state_t state, state_next;

  // Configuration registers.
  logic [CFG_W-1:0] threshold_offset;
  logic [CFG_W-1:0] min_interval_ms;
  logic [CFG_W-1:0] max_interval_ms;

  // Detector state.
  logic [LEVEL_W-1:0] running_level;
  logic               above_flag;
  logic [TIME_W-1:0]  last_peak_ms;
  logic               peak_seen;
  logic [RATE_W-1:0]  last_bpm;
  logic [RATE_W-1:0]  avg_bpm;
  logic [IDX_W-1:0]   write_slot;
  logic [CNT_W-1:0]   fill_count;

  // Working registers for the item in flight.
  logic [SAMPLE_W-1:0] sample;
  logic [TIME_W-1:0]   stamp;
  logic [SUM9_W-1:0]   sum9;
  logic [SUM_W-1:0]    total;
  logic [CNT_W-1:0]    rd_cnt;
  logic                rd_pend;
  logic                beat_hit;

  // Datapath terms.
  logic [SUM9_W-1:0]   sum9_next;
  logic [PROD_W-1:0]   prod;
  logic [LEVEL_W:0]    threshold;
  logic                rising;
  logic                falling;
  logic [TIME_W-1:0]   gap;
  logic                qualify;
  logic                sum_issue;
  logic                sum_done;
  logic                out_free;

  // Divider and memory interface.
  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [SUM_W-1:0]    div_dividend;
  logic [RATE_W-1:0]   div_divisor;
  logic [SUM_W-1:0]    div_quo;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_raddr;
  logic [RATE_W-1:0]   ram_rdata;

  assign sum9_next = SUM9_W'(running_level) * SUM9_W'(LEVEL_GAIN) + SUM9_W'(sample);
  assign prod      = PROD_W'(sum9) * PROD_W'(LEVEL_RECIP);
  assign threshold = {1'b0, running_level} + (LEVEL_W + 1)'(threshold_offset);
  assign rising    = !above_flag && ({1'b0, sample} > threshold);
  assign falling   = above_flag && ({1'b0, sample} < threshold);
  assign gap       = stamp - last_peak_ms;
  assign qualify   = rising && peak_seen
                     && (gap > TIME_W'(min_interval_ms))
                     && (gap < TIME_W'(max_interval_ms));
  assign sum_issue = (rd_cnt < fill_count);
  assign sum_done  = !sum_issue && !rd_pend;
  assign out_free  = !out_valid || out_ready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = ST_SCALE;
      ST_SCALE:   state_next = ST_LEVEL;
      ST_LEVEL:   state_next = ST_CMP;
      ST_CMP:     state_next = qualify ? ST_DIV_BPM : ST_OUT;
      ST_DIV_BPM: if (div_stat.done) state_next = ST_SUM;
      ST_SUM:     if (sum_done) state_next = ST_DIV_AVG;
      ST_DIV_AVG: if (div_stat.done) state_next = ST_OUT;
      ST_OUT:     if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready      = 1'b0;
    div_req.start = 1'b0;
    div_dividend  = SUM_W'(BPM_NUMERATOR);
    div_divisor   = gap[RATE_W-1:0];
    ram_we        = 1'b0;
    case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_CMP:     div_req.start = qualify;
      ST_DIV_BPM: ram_we = div_stat.done;
      ST_SUM: begin
        div_req.start = sum_done;
        div_dividend  = total;
        div_divisor   = RATE_W'(fill_count);
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign ram_raddr = rd_cnt[IDX_W-1:0];

  // Configuration writes; an unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_offset <= RST_THRESHOLD_OFFSET;
      min_interval_ms  <= RST_MIN_INTERVAL;
      max_interval_ms  <= RST_MAX_INTERVAL;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD_OFFSET: threshold_offset <= cfg_data;
        CFG_MIN_INTERVAL:     min_interval_ms  <= cfg_data;
        CFG_MAX_INTERVAL:     max_interval_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control and detector state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      running_level <= '0;
      above_flag    <= 1'b0;
      last_peak_ms  <= '0;
      peak_seen     <= 1'b0;
      last_bpm      <= '0;
      avg_bpm       <= '0;
      write_slot    <= '0;
      fill_count    <= '0;
      rd_pend       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_LEVEL: running_level <= prod[LEVEL_SHIFT +: LEVEL_W];
        ST_CMP: begin
          if (rising) begin
            above_flag   <= 1'b1;
            last_peak_ms <= stamp;
            peak_seen    <= 1'b1;
          end else if (falling) begin
            above_flag <= 1'b0;
          end
        end
        ST_DIV_BPM: begin
          if (div_stat.done) begin
            last_bpm   <= div_quo[RATE_W-1:0];
            write_slot <= (write_slot == IDX_W'(WINDOW_LEN - 1)) ? '0 : write_slot + 1'b1;
            if (fill_count < CNT_W'(WINDOW_LEN)) begin
              fill_count <= fill_count + 1'b1;
            end
            rd_pend <= 1'b0;
          end
        end
        ST_SUM:     rd_pend <= sum_issue;
        ST_DIV_AVG: if (div_stat.done) avg_bpm <= div_quo[RATE_W-1:0];
        default: ;
      endcase
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and the output payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sample <= ir_sample;
        stamp  <= time_ms;
      end
      ST_SCALE: sum9 <= sum9_next;
      ST_CMP:   beat_hit <= 1'b0;
      ST_DIV_BPM: begin
        total  <= '0;
        rd_cnt <= '0;
      end
      ST_SUM: begin
        if (sum_issue) begin
          rd_cnt <= rd_cnt + 1'b1;
        end
        if (rd_pend) begin
          total <= total + SUM_W'(ram_rdata);
        end
      end
      ST_DIV_AVG: if (div_stat.done) beat_hit <= 1'b1;
      ST_OUT: begin
        if (out_free) begin
          beat    <= beat_hit;
          bpm_raw <= last_bpm;
          bpm_avg <= avg_bpm;
        end
      end
      default: ;
    endcase
  end

  pbd_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (RATE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  pbd_ram #(
    .DEPTH  (WINDOW_LEN),
    .DATA_W (RATE_W),
    .ADDR_W (IDX_W)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (div_quo[RATE_W-1:0]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
